### design/bucketed_delta_timer_queue_core_assert.svh
// Assertion macros for the bucketed delta timer queue.
// Included by the top level; expects clk and rst in scope.
`ifndef BUCKETED_DELTA_TIMER_QUEUE_CORE_ASSERT_SVH
`define BUCKETED_DELTA_TIMER_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BDTQ_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BDTQ_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

### design/bdtq_pkg.sv
// Shared types, constants and helpers of the bucketed delta timer queue.
// No dependencies.
`default_nettype none
package bdtq_pkg;

  localparam int NUM_BUCKETS        = 64;
  localparam int ENTRIES_PER_BUCKET = 16;
  localparam int HANDLE_BITS        = 16;

  localparam int IDX_W   = $clog2(NUM_BUCKETS);
  localparam int USED_W  = $clog2(NUM_BUCKETS + 1);
  localparam int ENT_W   = $clog2(ENTRIES_PER_BUCKET);
  localparam int CNT_W   = $clog2(ENTRIES_PER_BUCKET + 1);
  localparam int DELTA_W = 20;
  // Remaining time: timeout minus up to NUM_BUCKETS deltas.
  localparam int REM_W   = DELTA_W + IDX_W + 1;
  localparam int ADDR_W  = IDX_W + ENT_W;
  localparam int DEPTH   = NUM_BUCKETS * ENTRIES_PER_BUCKET;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_SERVICE = 2'd2;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_REFUSED  = 2'd1;
  localparam logic [1:0] ST_EXPIRED  = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        kind;
    logic [15:0] handle;
    logic [15:0] idle_tmo;
    logic [15:0] hard_tmo;
    logic [15:0] idle_age;
    logic [15:0] hard_age;
    logic [15:0] direct_timeout;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        out_kind;
    logic [15:0] out_handle;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [DELTA_W-1:0] delta;
    logic               kind;
    logic [CNT_W-1:0]   count;
    logic [IDX_W-1:0]   slot;
  } bkt_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROTATE,
    CELL_PLACE
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [USED_W-1:0] pos;
    logic [USED_W-1:0] used;
    bkt_t              new_bkt;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_PLACE,
    S_RESP,
    S_EM_RD,
    S_EM_WT
  } state_t;

  // Clamp a wide signed value to the stored delta range.
  function automatic logic [DELTA_W-1:0] sat_delta(input logic [REM_W-1:0] v);
    logic pos_ovf;
    logic neg_ovf;
    pos_ovf = !v[REM_W-1] && (|v[REM_W-2:DELTA_W-1]);
    neg_ovf = v[REM_W-1] && !(&v[REM_W-2:DELTA_W-1]);
    if (pos_ovf) begin
      sat_delta = {1'b0, {(DELTA_W-1){1'b1}}};
    end else if (neg_ovf) begin
      sat_delta = {1'b1, {(DELTA_W-1){1'b0}}};
    end else begin
      sat_delta = v[DELTA_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

### design/bdtq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bdtq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

### design/bdtq_cell.sv
// One bucket cell of the ordered ring; rotates toward the head or opens a gap.
// Depends on bdtq_pkg.
`default_nettype none
module bdtq_cell (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [bdtq_pkg::IDX_W-1:0]     idx,
  input  wire bdtq_pkg::cell_ctrl_t           ctrl,
  input  wire bdtq_pkg::bkt_t                 right_in,
  input  wire bdtq_pkg::bkt_t                 left_in,
  output bdtq_pkg::bkt_t                      q
);
  logic [bdtq_pkg::USED_W-1:0] my_pos;

  assign my_pos = {1'b0, idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      q.delta <= '0;
      q.kind  <= 1'b0;
      q.count <= '0;
      q.slot  <= idx;
    end else begin
      case (ctrl.op)
        bdtq_pkg::CELL_ROTATE: q <= right_in;
        bdtq_pkg::CELL_PLACE: begin
          if (my_pos == ctrl.pos) begin
            q <= ctrl.new_bkt;
          end else if (my_pos > ctrl.pos && my_pos <= ctrl.used) begin
            q <= left_in;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

### design/bucketed_delta_timer_queue_core.sv
// Top level of the bucketed delta timer queue: ring of bucket cells, walk
// controller and handle RAM. Depends on bdtq_pkg, bdtq_cell, bdtq_ram.
//
//  channel | valid        | stall        | beat
//  --------+--------------+--------------+----------------------------
//  input   | item_valid   | item_stall   | item   (bdtq_pkg::item_t)
//  output  | result_valid | result_stall | result (bdtq_pkg::result_t)
//
// Insert and tick rotate the whole ring once, inspecting the head cell at each
// walk step; insert then places the bucket and issues its result.
// Service: per expired handle, a RAM read, then an output load.
// One beat is in work at a time; item_stall is high until it is done.
// A stalled result holds the controller in its result state. Reset is sync;
// the ring comes up empty with identity slot order, the handle RAM is not cleared.
`default_nettype none
module bucketed_delta_timer_queue_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire bdtq_pkg::item_t   item,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output bdtq_pkg::result_t      result
);
  localparam int NB = bdtq_pkg::NUM_BUCKETS;
  localparam int IW = bdtq_pkg::IDX_W;
  localparam int UW = bdtq_pkg::USED_W;
  localparam int RW = bdtq_pkg::REM_W;
  localparam int DW = bdtq_pkg::DELTA_W;
  localparam int CW = bdtq_pkg::CNT_W;
  localparam int EW = bdtq_pkg::ENT_W;
  localparam int AW = bdtq_pkg::ADDR_W;

  // ---- registers ----
  bdtq_pkg::state_t  state, state_next;
  logic [IW-1:0]     k, k_next;              // walk step = position at head
  logic [UW-1:0]     used, used_next;        // live buckets
  logic [RW-1:0]     rem, rem_next;          // timeout minus deadlines passed
  logic              found, found_next;
  logic              joined, joined_next;
  logic              refused, refused_next;
  logic [UW-1:0]     pos, pos_next;
  logic [IW-1:0]     free_slot, free_slot_next;
  logic [IW-1:0]     jslot, jslot_next;
  logic [EW-1:0]     jcnt, jcnt_next;
  logic [1:0]        op_r, op_r_next;
  logic              kind_r, kind_r_next;
  logic [15:0]       handle_r, handle_r_next;
  logic [IW-1:0]     es_slot, es_slot_next;
  logic              es_kind, es_kind_next;
  logic [CW-1:0]     es_cnt, es_cnt_next;
  logic [CW-1:0]     e_idx, e_idx_next;
  logic              result_valid_next;
  bdtq_pkg::result_t result_next;

  // ---- ring and RAM ----
  bdtq_pkg::bkt_t     cq [NB];
  bdtq_pkg::bkt_t     ring_in;
  bdtq_pkg::cell_ctrl_t cctrl;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [15:0]        ram_wdata, ram_rdata;

  // ---- helpers ----
  logic              out_free;
  logic [16:0]       idle_left, hard_left, timeout;
  logic [RW-1:0]     hdelta;
  logic [RW-1:0]     d_ext;
  logic [DW-1:0]     d_sat;
  logic [DW-1:0]     adj_delta;
  logic              live;
  logic              place_new;

  assign item_stall = (state != bdtq_pkg::S_IDLE);
  assign out_free   = !result_valid || !result_stall;

  // Timeout of the incoming entry: direct timeout when kind is set, else min of idle and hard remaining when both set.
  always_comb begin
    idle_left = {1'b0, item.idle_tmo} - {1'b0, item.idle_age};
    hard_left = {1'b0, item.hard_tmo} - {1'b0, item.hard_age};
    if (item.kind) begin
      timeout = {1'b0, item.direct_timeout};
    end else if (item.idle_tmo != '0 && item.hard_tmo != '0) begin
      timeout = ($signed(idle_left) < $signed(hard_left)) ? idle_left : hard_left;
    end else if (item.idle_tmo != '0) begin
      timeout = idle_left;
    end else begin
      timeout = hard_left;
    end
  end

  assign hdelta    = {{(RW-DW){cq[0].delta[DW-1]}}, cq[0].delta};
  assign d_sat     = bdtq_pkg::sat_delta(rem);
  assign d_ext     = hdelta - {{(RW-DW){d_sat[DW-1]}}, d_sat};
  assign adj_delta = bdtq_pkg::sat_delta(d_ext);
  assign live      = ({1'b0, k} < used);
  assign place_new = (state == bdtq_pkg::S_PLACE) && !joined && (used != UW'(NB));

  always_comb begin
    state_next        = state;
    k_next            = k;
    used_next         = used;
    rem_next          = rem;
    found_next        = found;
    joined_next       = joined;
    refused_next      = refused;
    pos_next          = pos;
    free_slot_next    = free_slot;
    jslot_next        = jslot;
    jcnt_next         = jcnt;
    op_r_next         = op_r;
    kind_r_next       = kind_r;
    handle_r_next     = handle_r;
    es_slot_next      = es_slot;
    es_kind_next      = es_kind;
    es_cnt_next       = es_cnt;
    e_idx_next        = e_idx;
    result_next       = result;
    result_valid_next = result_valid && result_stall;
    ring_in           = cq[0];
    cctrl.op          = bdtq_pkg::CELL_HOLD;
    cctrl.pos         = pos;
    cctrl.used        = used;
    cctrl.new_bkt.delta = d_sat;
    cctrl.new_bkt.kind  = kind_r;
    cctrl.new_bkt.count = CW'(1);
    cctrl.new_bkt.slot  = free_slot;
    ram_we    = 1'b0;
    ram_waddr = {free_slot, {EW{1'b0}}};
    ram_wdata = handle_r;
    ram_re    = 1'b0;
    ram_raddr = {es_slot, e_idx[EW-1:0]};

    case (state)
      bdtq_pkg::S_IDLE: begin
        if (item_valid) begin
          op_r_next     = item.opcode;
          kind_r_next   = item.kind;
          handle_r_next = item.handle;
          k_next        = '0;
          case (item.opcode)
            bdtq_pkg::OP_INSERT: begin
              rem_next    = {{(RW-17){timeout[16]}}, timeout};
              found_next  = 1'b0;
              joined_next = 1'b0;
              pos_next    = used;
              state_next  = bdtq_pkg::S_WALK;
            end
            bdtq_pkg::OP_TICK: begin
              state_next = bdtq_pkg::S_WALK;
            end
            bdtq_pkg::OP_SERVICE: begin
              // Due when the head delta is zero or negative.
              if (used != '0 && (cq[0].delta[DW-1] || cq[0].delta == '0)) begin
                es_slot_next = cq[0].slot;
                es_kind_next = cq[0].kind;
                es_cnt_next  = cq[0].count;
                e_idx_next   = '0;
                state_next   = bdtq_pkg::S_EM_RD;
              end
            end
            default: ;
          endcase
        end
      end

      bdtq_pkg::S_WALK: begin
        cctrl.op = bdtq_pkg::CELL_ROTATE;
        k_next   = k + IW'(1);
        if (op_r == bdtq_pkg::OP_INSERT) begin
          if ({1'b0, k} == used) begin
            free_slot_next = cq[0].slot;
          end
          if (!found && live) begin
            if ($signed(hdelta) > $signed(rem)) begin
              // New bucket goes here; the bucket now at head follows it.
              found_next = 1'b1;
              pos_next   = {1'b0, k};
              if (used != UW'(NB)) begin
                ring_in.delta = adj_delta;
              end
            end else if (hdelta == rem && cq[0].kind == kind_r &&
                         cq[0].count < CW'(bdtq_pkg::ENTRIES_PER_BUCKET)) begin
              found_next    = 1'b1;
              joined_next   = 1'b1;
              jslot_next    = cq[0].slot;
              jcnt_next     = cq[0].count[EW-1:0];
              ring_in.count = cq[0].count + CW'(1);
            end else begin
              rem_next = rem - hdelta;
            end
          end
        end else begin
          // Tick: count the head down while it is still positive.
          if (k == '0 && used != '0 && !cq[0].delta[DW-1] && cq[0].delta != '0) begin
            ring_in.delta = cq[0].delta - DW'(1);
          end
        end
        if (k == IW'(NB - 1)) begin
          state_next = (op_r == bdtq_pkg::OP_INSERT) ? bdtq_pkg::S_PLACE
                                                     : bdtq_pkg::S_IDLE;
        end
      end

      bdtq_pkg::S_PLACE: begin
        refused_next = 1'b0;
        if (joined) begin
          ram_we    = 1'b1;
          ram_waddr = {jslot, jcnt};
        end else if (used != UW'(NB)) begin
          cctrl.op  = bdtq_pkg::CELL_PLACE;
          ram_we    = 1'b1;
          used_next = used + UW'(1);
        end else begin
          refused_next = 1'b1;
        end
        state_next = bdtq_pkg::S_RESP;
      end

      bdtq_pkg::S_RESP: begin
        if (out_free) begin
          result_valid_next      = 1'b1;
          result_next.status     = refused ? bdtq_pkg::ST_REFUSED : bdtq_pkg::ST_INSERTED;
          result_next.out_kind   = kind_r;
          result_next.out_handle = handle_r;
          result_next.last       = 1'b1;
          state_next             = bdtq_pkg::S_IDLE;
        end
      end

      bdtq_pkg::S_EM_RD: begin
        ram_re     = 1'b1;
        state_next = bdtq_pkg::S_EM_WT;
      end

      bdtq_pkg::S_EM_WT: begin
        if (out_free) begin
          result_valid_next      = 1'b1;
          result_next.status     = bdtq_pkg::ST_EXPIRED;
          result_next.out_kind   = es_kind;
          result_next.out_handle = ram_rdata;
          result_next.last       = (e_idx + CW'(1) == es_cnt);
          if (e_idx + CW'(1) == es_cnt) begin
            // Drop the head: one ring step moves it behind the free slots.
            cctrl.op   = bdtq_pkg::CELL_ROTATE;
            used_next  = used - UW'(1);
            state_next = bdtq_pkg::S_IDLE;
          end else begin
            e_idx_next = e_idx + CW'(1);
            state_next = bdtq_pkg::S_EM_RD;
          end
        end
      end

      default: state_next = bdtq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= bdtq_pkg::S_IDLE;
      used         <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      used         <= used_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    k         <= k_next;
    rem       <= rem_next;
    found     <= found_next;
    joined    <= joined_next;
    refused   <= refused_next;
    pos       <= pos_next;
    free_slot <= free_slot_next;
    jslot     <= jslot_next;
    jcnt      <= jcnt_next;
    op_r      <= op_r_next;
    kind_r    <= kind_r_next;
    handle_r  <= handle_r_next;
    es_slot   <= es_slot_next;
    es_kind   <= es_kind_next;
    es_cnt    <= es_cnt_next;
    e_idx     <= e_idx_next;
    result    <= result_next;
  end

  // ---- ring of cells; position 0 is the queue head ----
  for (genvar i = 0; i < NB; i++) begin : g_cell
    bdtq_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (IW'(i)),
      .ctrl     (cctrl),
      .right_in ((i == NB - 1) ? ring_in : cq[(i + 1) % NB]),
      .left_in  ((i == 0) ? cq[0] : cq[(i + NB - 1) % NB]),
      .q        (cq[i])
    );
  end

  bdtq_ram #(
    .WIDTH (16),
    .DEPTH (bdtq_pkg::DEPTH)
  ) u_handles (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---- checks ----
`include "bucketed_delta_timer_queue_core_assert.svh"
  `BDTQ_ASSERT_NOW(a_used_range, 1'b1, used <= UW'(NB), "live bucket count out of range")
  `BDTQ_ASSERT_NOW(a_emit_count, state == bdtq_pkg::S_EM_WT, e_idx < es_cnt, "bad emit index")
  `BDTQ_ASSERT_NEXT(a_place_grow, place_new, used == $past(used) + UW'(1), "bucket not counted")

endmodule
`default_nettype wire
